/* sv/measurement_ingest_tracker_assert.svh */
// ----------------------------------------------------------------------------
// measurement ingest tracker assertion macros
// property templates shared by the checker of the tracker ports
// ----------------------------------------------------------------------------
`ifndef MEASUREMENT_INGEST_TRACKER_ASSERT_SVH
`define MEASUREMENT_INGEST_TRACKER_ASSERT_SVH

// same-cycle implication
`define MIT_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tracker port check failed");

// delayed implication
`define MIT_ASSERT_DELAY2(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##2 (b)) \
        else $error("tracker timing check failed");

`endif

/* sv/mit_pkg.sv */
// ----------------------------------------------------------------------------
// mit_pkg
// types and constants of the measurement ingest tracker
// ----------------------------------------------------------------------------
package mit_pkg;

    localparam int ID_W     = 10;
    localparam int TIME_W   = 64;
    localparam int FLAG_W   = 16;
    localparam int SRC_W    = 16;
    localparam int VALUE_W  = 64;
    localparam int CAP_W    = 21;
    localparam int WPOS_W   = 21;
    localparam int POS_W    = 20;
    localparam int SPAN_W   = 11;

    localparam int SERIES_COUNT = 1024;
    localparam int MAX_RECORDS  = 1048576;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1048576);

    typedef enum logic
    {
        FUNC_APPEND = 1'b0,
        FUNC_READ   = 1'b1
    } func_t;

    typedef struct packed
    {
        logic               valid;
        logic [TIME_W-1:0]  time_stamp;
        logic [FLAG_W-1:0]  flag;
        logic [SRC_W-1:0]   source;
        logic [VALUE_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* sv/mit_ram.sv */
// ----------------------------------------------------------------------------
// mit_ram
// simple dual-port ram, one write port, one registered read port (read-first)
// ----------------------------------------------------------------------------
module mit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/measurement_ingest_tracker.sv */
// ----------------------------------------------------------------------------
// measurement_ingest_tracker
// tracks write position, time and id bounds and the latest entry per id
// ----------------------------------------------------------------------------
// After reset busy stays high while the latest-entry table is swept to empty,
// entry by entry from id 0 to SERIES_COUNT-1; configuration writes are taken
// during that time. Afterwards busy stays low and one item is taken on every
// clock at which start is high. Each item gives exactly one result beat, on
// done for a single cycle, registered via s1_valid_reg and done_reg; results
// come in item order and cannot be held off. The rate of one item per clock
// is set by the read-modify-write of the latest-entry ram, whose registered
// read is bypassed from the previous write when both touch the same id.
module measurement_ingest_tracker #(
    parameter int SERIES_COUNT = mit_pkg::SERIES_COUNT
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         start,
    output logic                         busy,
    input  logic                         func,
    input  logic [mit_pkg::ID_W-1:0]     meas_id,
    input  logic [mit_pkg::TIME_W-1:0]   meas_time,
    input  logic [mit_pkg::FLAG_W-1:0]   meas_flag,
    input  logic [mit_pkg::SRC_W-1:0]    meas_source,
    input  logic [mit_pkg::VALUE_W-1:0]  meas_value,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mit_pkg::CAP_W-1:0]    cfg_data,

    output logic                         done,
    output logic                         accepted,
    output logic [mit_pkg::POS_W-1:0]    position,
    output logic [mit_pkg::TIME_W-1:0]   min_time,
    output logic [mit_pkg::TIME_W-1:0]   max_time,
    output logic [mit_pkg::ID_W-1:0]     min_series,
    output logic [mit_pkg::ID_W-1:0]     max_series,
    output logic [mit_pkg::SPAN_W-1:0]   window_count,
    output logic                         latest_valid,
    output logic [mit_pkg::TIME_W-1:0]   latest_time,
    output logic [mit_pkg::FLAG_W-1:0]   latest_flag,
    output logic [mit_pkg::SRC_W-1:0]    latest_source,
    output logic [mit_pkg::VALUE_W-1:0]  latest_value
);

    localparam int AW    = $clog2(SERIES_COUNT);
    localparam int EXT_W = (AW > mit_pkg::ID_W) ? AW : mit_pkg::ID_W;

    // control registers
    logic                          clr_active_reg;
    logic [AW-1:0]                 clr_cnt_reg;
    logic [mit_pkg::CAP_W-1:0]     cap_reg;
    logic [mit_pkg::WPOS_W-1:0]    wpos_reg, wpos_next;
    logic                          loaded_reg, loaded_next;
    logic [mit_pkg::TIME_W-1:0]    lo_time_reg, lo_time_next;
    logic [mit_pkg::TIME_W-1:0]    hi_time_reg, hi_time_next;
    logic [mit_pkg::ID_W-1:0]      lo_ser_reg, lo_ser_next;
    logic [mit_pkg::ID_W-1:0]      hi_ser_reg, hi_ser_next;
    logic [mit_pkg::SPAN_W-1:0]    span_reg, span_next;
    logic                          s1_valid_reg;
    logic                          fwd_hit_reg, fwd_hit_next;
    logic                          done_reg;

    // payload registers
    logic                          s1_func_reg;
    logic [mit_pkg::ID_W-1:0]      s1_id_reg;
    logic [mit_pkg::TIME_W-1:0]    s1_time_reg;
    logic [mit_pkg::FLAG_W-1:0]    s1_flag_reg;
    logic [mit_pkg::SRC_W-1:0]     s1_src_reg;
    logic [mit_pkg::VALUE_W-1:0]   s1_value_reg;
    mit_pkg::entry_t               fwd_entry_reg;
    logic                          accepted_reg;
    logic [mit_pkg::POS_W-1:0]     position_reg;
    mit_pkg::entry_t               latest_reg, latest_next;

    // datapath
    logic                          take;
    logic [EXT_W-1:0]              in_id_ext, s1_id_ext;
    logic [AW-1:0]                 rd_addr, s1_addr;
    logic                          s1_in_table;
    logic [mit_pkg::CAP_W-1:0]     page_limit;
    logic                          append_ok;
    logic                          replace;
    logic [mit_pkg::SPAN_W-1:0]    id_plus_one;
    mit_pkg::entry_t               cur_entry, new_entry;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    mit_pkg::entry_t               ram_wdata;
    logic [mit_pkg::ENTRY_W-1:0]   ram_rdata;

    assign busy      = clr_active_reg;
    assign cfg_ready = 1'b1;
    assign take      = start && !clr_active_reg;

    assign in_id_ext   = EXT_W'(meas_id);
    assign s1_id_ext   = EXT_W'(s1_id_reg);
    assign rd_addr     = in_id_ext[AW-1:0];
    assign s1_addr     = s1_id_ext[AW-1:0];
    assign s1_in_table = 32'(s1_id_reg) < SERIES_COUNT;

    assign page_limit = (32'(cap_reg) > mit_pkg::MAX_RECORDS)
                      ? mit_pkg::CAP_W'(mit_pkg::MAX_RECORDS) : cap_reg;

    assign append_ok = s1_valid_reg && (s1_func_reg == mit_pkg::FUNC_APPEND)
                    && (wpos_reg < page_limit);

    assign cur_entry = fwd_hit_reg ? fwd_entry_reg : mit_pkg::entry_t'(ram_rdata);

    assign replace = append_ok && s1_in_table
                  && (!cur_entry.valid || (cur_entry.time_stamp < s1_time_reg));

    always_comb
    begin
        new_entry.valid      = 1'b1;
        new_entry.time_stamp = s1_time_reg;
        new_entry.flag       = s1_flag_reg;
        new_entry.source     = s1_src_reg;
        new_entry.value      = s1_value_reg;
    end

    // table write: clearing sweep after reset, else the replacement
    assign ram_we    = clr_active_reg || replace;
    assign ram_waddr = clr_active_reg ? clr_cnt_reg : s1_addr;
    assign ram_wdata = clr_active_reg ? '0 : new_entry;

    assign fwd_hit_next = ram_we && (ram_waddr == rd_addr);

    mit_ram #(
        .WIDTH (mit_pkg::ENTRY_W),
        .DEPTH (SERIES_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign id_plus_one = mit_pkg::SPAN_W'(s1_id_reg) + mit_pkg::SPAN_W'(1);

    always_comb
    begin
        wpos_next    = wpos_reg;
        loaded_next  = loaded_reg;
        lo_time_next = lo_time_reg;
        hi_time_next = hi_time_reg;
        lo_ser_next  = lo_ser_reg;
        hi_ser_next  = hi_ser_reg;
        span_next    = span_reg;
        if (append_ok)
        begin
            wpos_next   = wpos_reg + mit_pkg::WPOS_W'(1);
            loaded_next = 1'b1;
            if (loaded_reg)
            begin
                if (s1_time_reg < lo_time_reg)
                begin
                    lo_time_next = s1_time_reg;
                end
                if (s1_time_reg > hi_time_reg)
                begin
                    hi_time_next = s1_time_reg;
                end
                if (s1_id_reg < lo_ser_reg)
                begin
                    lo_ser_next = s1_id_reg;
                end
                if (s1_id_reg > hi_ser_reg)
                begin
                    hi_ser_next = s1_id_reg;
                end
            end
            else
            begin
                lo_time_next = s1_time_reg;
                hi_time_next = s1_time_reg;
                lo_ser_next  = s1_id_reg;
                hi_ser_next  = s1_id_reg;
            end
            if (id_plus_one > span_reg)
            begin
                span_next = id_plus_one;
            end
        end
    end

    always_comb
    begin
        if (replace)
        begin
            latest_next = new_entry;
        end
        else if (s1_in_table && cur_entry.valid)
        begin
            latest_next = cur_entry;
        end
        else
        begin
            latest_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            cap_reg        <= mit_pkg::CAP_RESET;
            wpos_reg       <= '0;
            loaded_reg     <= 1'b0;
            lo_time_reg    <= '0;
            hi_time_reg    <= '0;
            lo_ser_reg     <= '0;
            hi_ser_reg     <= '0;
            span_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(SERIES_COUNT - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            wpos_reg     <= wpos_next;
            loaded_reg   <= loaded_next;
            lo_time_reg  <= lo_time_next;
            hi_time_reg  <= hi_time_next;
            lo_ser_reg   <= lo_ser_next;
            hi_ser_reg   <= hi_ser_next;
            span_reg     <= span_next;
            s1_valid_reg <= take;
            fwd_hit_reg  <= fwd_hit_next;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_func_reg  <= func;
            s1_id_reg    <= meas_id;
            s1_time_reg  <= meas_time;
            s1_flag_reg  <= meas_flag;
            s1_src_reg   <= meas_source;
            s1_value_reg <= meas_value;
        end
        fwd_entry_reg <= ram_wdata;
        accepted_reg  <= append_ok;
        position_reg  <= append_ok ? wpos_reg[mit_pkg::POS_W-1:0] : '0;
        latest_reg    <= latest_next;
    end

    // result beat
    assign done          = done_reg;
    assign accepted      = accepted_reg;
    assign position      = position_reg;
    assign min_time      = lo_time_reg;
    assign max_time      = hi_time_reg;
    assign min_series    = lo_ser_reg;
    assign max_series    = hi_ser_reg;
    assign window_count  = span_reg;
    assign latest_valid  = latest_reg.valid;
    assign latest_time   = latest_reg.time_stamp;
    assign latest_flag   = latest_reg.flag;
    assign latest_source = latest_reg.source;
    assign latest_value  = latest_reg.value;

endmodule

/* sv/mit_checker.sv */
// ----------------------------------------------------------------------------
// mit_checker
// port-level checks of the measurement ingest tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "measurement_ingest_tracker_assert.svh"

module mit_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         done,
    input  logic                         accepted,
    input  logic [mit_pkg::TIME_W-1:0]   min_time,
    input  logic [mit_pkg::TIME_W-1:0]   max_time,
    input  logic [mit_pkg::ID_W-1:0]     min_series,
    input  logic [mit_pkg::ID_W-1:0]     max_series,
    input  logic [mit_pkg::SPAN_W-1:0]   window_count,
    input  logic                         latest_valid,
    input  logic [mit_pkg::TIME_W-1:0]   latest_time,
    input  logic [mit_pkg::FLAG_W-1:0]   latest_flag,
    input  logic [mit_pkg::SRC_W-1:0]    latest_source,
    input  logic [mit_pkg::VALUE_W-1:0]  latest_value
);

    // every taken item gives its beat, and no beat comes without a taken item
    `MIT_ASSERT_DELAY2(a_beat_follows, clk, rst_n, start && !busy, done)
    `MIT_ASSERT_DELAY2(a_no_stray_beat, clk, rst_n, !(start && !busy), !done)

    // bounds are consistent once an append has been stored
    `MIT_ASSERT_IMPLIES(a_bounds_order, clk, rst_n, done && accepted,
        (min_time <= max_time) && (min_series <= max_series)
        && (window_count == (mit_pkg::SPAN_W'(max_series) + mit_pkg::SPAN_W'(1))))

    // an empty latest entry reads as zero
    `MIT_ASSERT_IMPLIES(a_empty_entry_zero, clk, rst_n, done && !latest_valid,
        (latest_time == '0) && (latest_flag == '0)
        && (latest_source == '0) && (latest_value == '0))

endmodule

bind measurement_ingest_tracker mit_checker u_mit_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .accepted      (accepted),
    .min_time      (min_time),
    .max_time      (max_time),
    .min_series    (min_series),
    .max_series    (max_series),
    .window_count  (window_count),
    .latest_valid  (latest_valid),
    .latest_time   (latest_time),
    .latest_flag   (latest_flag),
    .latest_source (latest_source),
    .latest_value  (latest_value)
);
